>>> hdl/lcdseq_pkg.sv
package lcdseq_pkg;

    // Request codes
    localparam logic [2:0] FUNC_CMD    = 3'd0;
    localparam logic [2:0] FUNC_DATA   = 3'd1;
    localparam logic [2:0] FUNC_CURSOR = 3'd2;
    localparam logic [2:0] FUNC_CLEAR  = 3'd3;
    localparam logic [2:0] FUNC_INIT   = 3'd4;

    localparam logic [7:0]  STROBE_HOLD_RESET = 8'd20;
    localparam logic [7:0]  CLEAR_CMD         = 8'h01;
    localparam int          EXTRA_W           = 14;      // largest extra is 10 ms
    localparam logic [EXTRA_W-1:0] CLEAR_EXTRA_US = 14'd2000;
    localparam logic [15:0] POWER_UP_WAIT_US  = 16'd50000;

    localparam int          IDX_W             = 6;
    localparam logic [IDX_W-1:0] BYTE_LAST_IDX = 6'd3;   // four phases per byte
    localparam logic [IDX_W-1:0] INIT_LAST_IDX = 6'd36;  // wait + nine bytes
    localparam logic [3:0]  INIT_LAST_CMD     = 4'd8;

    // One queued job for the back end
    typedef struct packed {
        logic               is_init;
        logic               rs;
        logic [7:0]         value;
        logic [EXTRA_W-1:0] extra_us;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // One pin phase
    typedef struct packed {
        logic        drive;
        logic        rs;
        logic [3:0]  nibble;
        logic        en;
        logic [15:0] hold_us;
        logic        last;
    } phase_t;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] b;
        case (row)
            2'd0:    b = 8'h80;
            2'd1:    b = 8'hC0;
            2'd2:    b = 8'h94;
            2'd3:    b = 8'hD4;
            default: b = 8'h80;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] init_cmd(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:    c = 8'h30;
            4'd1:    c = 8'h30;
            4'd2:    c = 8'h30;
            4'd3:    c = 8'h20;
            4'd4:    c = 8'h28;
            4'd5:    c = 8'h08;
            4'd6:    c = 8'h01;
            4'd7:    c = 8'h06;
            4'd8:    c = 8'h0C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [EXTRA_W-1:0] init_extra(input logic [3:0] i);
        logic [EXTRA_W-1:0] e;
        case (i)
            4'd0:    e = 14'd5000;
            4'd1:    e = 14'd1000;
            4'd2:    e = 14'd10000;
            4'd3:    e = 14'd10000;
            4'd4:    e = 14'd1000;
            4'd5:    e = 14'd1000;
            4'd6:    e = 14'd2000;
            4'd7:    e = 14'd1000;
            default: e = 14'd0;
        endcase
        return e;
    endfunction

endpackage

>>> hdl/lcdseq_front.sv
module lcdseq_front (
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [2:0]             func,
    input  logic [7:0]             byte_value,
    input  logic [1:0]             row,
    input  logic [4:0]             column,
    input  lcdseq_pkg::q_status_t  q_status,
    output logic                   push,
    output lcdseq_pkg::job_t       job
);

    logic keep;

    assign req_stall = q_status.full;

    always_comb
    begin
        keep         = 1'b1;
        job.is_init  = 1'b0;
        job.rs       = 1'b0;
        job.value    = byte_value;
        job.extra_us = '0;
        case (func)
            lcdseq_pkg::FUNC_CMD:
            begin
                job.rs = 1'b0;
            end
            lcdseq_pkg::FUNC_DATA:
            begin
                job.rs = 1'b1;
            end
            lcdseq_pkg::FUNC_CURSOR:
            begin
                // column past 19 still just adds, wraps at 8 bits
                job.value = lcdseq_pkg::row_base(row) + {3'b000, column};
            end
            lcdseq_pkg::FUNC_CLEAR:
            begin
                job.value    = lcdseq_pkg::CLEAR_CMD;
                job.extra_us = lcdseq_pkg::CLEAR_EXTRA_US;
            end
            lcdseq_pkg::FUNC_INIT:
            begin
                job.is_init = 1'b1;
            end
            default:
            begin
                keep = 1'b0;   // unused codes are taken and dropped
            end
        endcase
    end

    assign push = req_valid && !q_status.full && keep;

endmodule

>>> hdl/lcdseq_queue.sv
module lcdseq_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lcdseq_pkg::job_t      push_job,
    input  logic                  pop,
    output lcdseq_pkg::job_t      head_job,
    output lcdseq_pkg::q_status_t status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lcdseq_pkg::job_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == CW'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hdl/lcdseq_back.sv
module lcdseq_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            strobe_hold_us,
    input  logic                  head_valid,
    input  lcdseq_pkg::job_t      head_job,
    output logic                  pop,
    output logic                  phase_valid,
    input  logic                  phase_stall,
    output lcdseq_pkg::phase_t    phase,
    output logic [lcdseq_pkg::IDX_W-1:0] idx
);

    logic [lcdseq_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                         out_valid_reg, out_valid_next;
    lcdseq_pkg::phase_t           out_reg, out_next;

    logic [lcdseq_pkg::IDX_W-1:0] j;
    logic [3:0]                   cmd;
    logic [1:0]                   sub;
    logic [7:0]                   value;
    logic [lcdseq_pkg::EXTRA_W-1:0] extra;
    logic                         last_phase;
    logic                         advance;
    logic                         load;
    lcdseq_pkg::phase_t           gen;

    // phase index within the job; init has a leading wait phase
    assign j   = head_job.is_init ? (idx_reg - 1'b1)
                                  : {{(lcdseq_pkg::IDX_W-2){1'b0}}, idx_reg[1:0]};
    assign sub = j[1:0];
    assign cmd = j[5:2];
    assign value = head_job.is_init ? lcdseq_pkg::init_cmd(cmd) : head_job.value;
    assign extra = head_job.is_init ? lcdseq_pkg::init_extra(cmd) : head_job.extra_us;
    assign last_phase = head_job.is_init ? (idx_reg == lcdseq_pkg::INIT_LAST_IDX)
                                         : (idx_reg == lcdseq_pkg::BYTE_LAST_IDX);

    always_comb
    begin
        if (head_job.is_init && idx_reg == '0)
        begin
            gen.drive   = 1'b0;
            gen.rs      = 1'b0;
            gen.nibble  = 4'h0;
            gen.en      = 1'b0;
            gen.hold_us = lcdseq_pkg::POWER_UP_WAIT_US;
            gen.last    = 1'b0;
        end
        else
        begin
            gen.drive   = 1'b1;
            gen.rs      = head_job.rs;
            gen.nibble  = sub[1] ? value[3:0] : value[7:4];
            gen.en      = !sub[0];
            gen.hold_us = 16'(strobe_hold_us)
                        + ((sub == 2'd3) ? 16'(extra) : 16'd0);
            gen.last    = (sub == 2'd3)
                        && (!head_job.is_init || cmd == lcdseq_pkg::INIT_LAST_CMD);
        end
    end

    assign advance = !out_valid_reg || !phase_stall;
    assign load    = advance && head_valid;
    assign pop     = load && last_phase;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = head_valid;
        end
        if (load)
        begin
            out_next = gen;
            idx_next = last_phase ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign phase_valid = out_valid_reg;
    assign phase       = out_reg;
    assign idx         = idx_reg;

endmodule

>>> hdl/char_lcd_nibble_write_sequencer_core.sv
// channel   | valid       | stall       | word
// ----------+-------------+-------------+------------------------------------------
// request   | req_valid   | req_stall   | func, byte_value, row, column
// phase     | phase_valid | phase_stall | drive, register_select, nibble,
//           |             |             | enable_line, hold_us, last
// config    | strobe_hold_we (no stall)   | strobe_hold_wdata
//
// One phase word leaves per cycle unless phase_stall holds it: a command, data,
// cursor or clear request is 4 phases, init is 37; the back end's phase counter
// sets this. Requests enter a QUEUE_DEPTH-entry job queue; req_stall is
// high only while that queue is full. Unused func codes are taken and dropped.
// phase_stall holds the output register; the front keeps filling the queue.
// Reset (rst_n, async low) empties the queue and sets the strobe hold to 20 us.
module char_lcd_nibble_write_sequencer_core #(
    parameter int QUEUE_DEPTH = 2    // 2 to 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        strobe_hold_we,
    input  logic [7:0]  strobe_hold_wdata,

    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  func,
    input  logic [7:0]  byte_value,
    input  logic [1:0]  row,
    input  logic [4:0]  column,

    output logic        phase_valid,
    input  logic        phase_stall,
    output logic        drive,
    output logic        register_select,
    output logic [3:0]  nibble,
    output logic        enable_line,
    output logic [15:0] hold_us,
    output logic        last
);

    logic [7:0]                   strobe_hold_reg;
    logic                         push;
    logic                         pop;
    lcdseq_pkg::job_t             push_job;
    lcdseq_pkg::job_t             head_job;
    lcdseq_pkg::q_status_t        q_status;
    lcdseq_pkg::phase_t           phase;
    logic [lcdseq_pkg::IDX_W-1:0] idx;

    // strobe hold register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_hold_reg <= lcdseq_pkg::STROBE_HOLD_RESET;
        end
        else if (strobe_hold_we)
        begin
            strobe_hold_reg <= strobe_hold_wdata;
        end
    end

    // front: decode request into a job
    lcdseq_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .func       (func),
        .byte_value (byte_value),
        .row        (row),
        .column     (column),
        .q_status   (q_status),
        .push       (push),
        .job        (push_job)
    );

    // job queue between front and back
    lcdseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // back: walk the job one phase per cycle, unless phase_stall holds it, into the output register
    lcdseq_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .strobe_hold_us (strobe_hold_reg),
        .head_valid     (!q_status.empty),
        .head_job       (head_job),
        .pop            (pop),
        .phase_valid    (phase_valid),
        .phase_stall    (phase_stall),
        .phase          (phase),
        .idx            (idx)
    );

    assign drive           = phase.drive;
    assign register_select = phase.rs;
    assign nibble          = phase.nibble;
    assign enable_line     = phase.en;
    assign hold_us         = phase.hold_us;
    assign last            = phase.last;

    // no write into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("job queue overflow");

    // back end only retires a job that is there
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("job queue underflow");

    // phase counter stays inside the longest job
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx <= lcdseq_pkg::INIT_LAST_IDX)
        else $error("phase index out of range");

    // wait-only phase leaves pins quiet and never ends a request
    a_wait_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_valid && !drive) |->
            (!register_select && nibble == 4'h0 && !enable_line && !last))
        else $error("wait phase with pin activity");

endmodule
